>>> rtl/core/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared constants, codes and control types of the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int DEF_MAX_RANGES  = 16;
  localparam int DEF_OFFSET_BITS = 32;
  localparam logic [31:0] TOTAL_RESET = 32'd65536;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_STEP    = 4'd2;
  localparam logic [3:0] OP_GRANT   = 4'd3;
  localparam logic [3:0] OP_SETPOS  = 4'd4;
  localparam logic [3:0] OP_UP      = 4'd5;
  localparam logic [3:0] OP_INSERT  = 4'd6;
  localparam logic [3:0] OP_MERGEN  = 4'd7;
  localparam logic [3:0] OP_DOWN    = 4'd8;
  localparam logic [3:0] OP_DEC     = 4'd9;
  localparam logic [3:0] OP_MERGEP  = 4'd10;
  localparam logic [3:0] OP_STATUS  = 4'd11;
  localparam logic [3:0] OP_PUBLISH = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] code;
  } cmd_t;

  typedef struct packed {
    logic act;
    logic size_zero;
    logic idx_lt;
    logic fit;
    logic exact;
    logic above;
    logic beyond;
    logic full;
    logic pos_end;
    logic idx_gt_pos;
    logic rem_more;
    logic next_ok;
    logic prev_ok;
  } stat_t;

endpackage

>>> rtl/core/ffra_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_datapath
// Free-range table, scan index, space size register and result registers.
// ----------------------------------------------------------------------------
module ffra_datapath #(
  parameter int MAX_RANGES  = ffra_pkg::DEF_MAX_RANGES,
  parameter int OFFSET_BITS = ffra_pkg::DEF_OFFSET_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr,
  input  logic [31:0]         cfg_data,
  output logic [31:0]         space_limit,
  input  logic                action,
  input  logic [31:0]         block_size,
  input  logic [31:0]         block_offset,
  input  ffra_pkg::cmd_t      cmd,
  output ffra_pkg::stat_t     stat,
  output logic [1:0]          status,
  output logic [31:0]         granted_offset
);
  import ffra_pkg::*;

  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int OB = OFFSET_BITS;

  logic [OB-1:0] range_start  [MAX_RANGES];
  logic [OB-1:0] range_length [MAX_RANGES];
  logic [CNT_W-1:0] count, idx, pos;
  logic act_q;
  logic [OB-1:0] size_q, offset_q;
  logic [1:0] res_status;
  logic [OB-1:0] res_granted;

  logic [IDX_W-1:0] ix, ixp, ixn, ixm, ppos, pnext, pprev;
  logic [OB:0] sum_cur, sum_prev;

  assign ix    = idx[IDX_W-1:0];
  assign ixp   = IDX_W'(idx + CNT_W'(1));
  assign ixm   = IDX_W'(idx - CNT_W'(1));
  assign ixn   = ixp;
  assign ppos  = pos[IDX_W-1:0];
  assign pnext = IDX_W'(pos + CNT_W'(1));
  assign pprev = IDX_W'(pos - CNT_W'(1));

  assign sum_cur  = {1'b0, range_start[ppos]} + {1'b0, range_length[ppos]};
  assign sum_prev = {1'b0, range_start[pprev]} + {1'b0, range_length[pprev]};

  always_comb begin
    stat.act        = act_q;
    stat.size_zero  = (size_q == '0);
    stat.idx_lt     = (idx < count);
    stat.fit        = (range_length[ix] >= size_q);
    stat.exact      = (range_length[ix] == size_q);
    stat.above      = (range_start[ix] > offset_q);
    stat.beyond     = (33'({1'b0, offset_q} + {1'b0, size_q}) > {1'b0, space_limit});
    stat.full       = (count == CNT_W'(MAX_RANGES));
    stat.pos_end    = (pos == count);
    stat.idx_gt_pos = (idx > pos);
    stat.rem_more   = ((CNT_W + 1)'(idx) + (CNT_W + 1)'(1) < (CNT_W + 1)'(count));
    stat.next_ok    = ((CNT_W + 1)'(pos) + (CNT_W + 1)'(1) < (CNT_W + 1)'(count)) &&
                      (sum_cur == {1'b0, range_start[pnext]});
    stat.prev_ok    = (pos != '0) && (sum_prev == {1'b0, range_start[ppos]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      space_limit <= TOTAL_RESET;
      count       <= (TOTAL_RESET[OB-1:0] != '0) ? CNT_W'(1) : '0;
      status      <= ST_OK;
    end else if (cfg_wr) begin
      space_limit <= cfg_data;
      count       <= (cfg_data[OB-1:0] != '0) ? CNT_W'(1) : '0;
    end else begin
      case (cmd.op)
        OP_INSERT: count <= count + CNT_W'(1);
        OP_DEC:    count <= count - CNT_W'(1);
        OP_PUBLISH: status <= res_status;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start[0]  <= '0;
      range_length[0] <= TOTAL_RESET[OB-1:0];
    end else if (cfg_wr) begin
      range_start[0]  <= '0;
      range_length[0] <= cfg_data[OB-1:0];
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          act_q       <= action;
          size_q      <= block_size[OB-1:0];
          offset_q    <= block_offset[OB-1:0];
          idx         <= '0;
          res_status  <= ST_OK;
          res_granted <= '0;
        end
        OP_STEP: idx <= idx + CNT_W'(1);
        OP_GRANT: begin
          res_granted      <= range_start[ix];
          res_status       <= ST_OK;
          range_start[ix]  <= range_start[ix] + size_q;
          range_length[ix] <= range_length[ix] - size_q;
        end
        OP_SETPOS: begin
          pos <= idx;
          idx <= count;
        end
        OP_UP: begin
          range_start[ix]  <= range_start[ixm];
          range_length[ix] <= range_length[ixm];
          idx <= idx - CNT_W'(1);
        end
        OP_INSERT: begin
          range_start[ppos]  <= offset_q;
          range_length[ppos] <= size_q;
          res_status         <= ST_OK;
        end
        OP_MERGEN: begin
          range_length[ppos] <= range_length[ppos] + range_length[pnext];
          idx <= pos + CNT_W'(1);
        end
        OP_MERGEP: begin
          range_length[pprev] <= range_length[pprev] + range_length[ppos];
          idx <= pos;
        end
        OP_DOWN: begin
          range_start[ix]  <= range_start[ixn];
          range_length[ix] <= range_length[ixn];
          idx <= idx + CNT_W'(1);
        end
        OP_STATUS: res_status <= cmd.code;
        OP_PUBLISH: granted_offset <= 32'(res_granted);
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RANGES)) else $error("range count exceeds table depth");
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_INSERT && !cfg_wr) |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table");
  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DEC && !cfg_wr) |=> count == $past(count) - CNT_W'(1))
    else $error("remove did not shrink the table");
`endif

endmodule

>>> rtl/core/ffra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer for scan, shift, merge and result hand-off of one word.
// ----------------------------------------------------------------------------
module ffra_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  ffra_pkg::stat_t stat,
  output ffra_pkg::cmd_t  cmd
);
  import ffra_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_SCAN_A = 4'd2;
  localparam logic [3:0] S_SCAN_F = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_UP     = 4'd5;
  localparam logic [3:0] S_MERGEN = 4'd6;
  localparam logic [3:0] S_MERGEP = 4'd7;
  localparam logic [3:0] S_REM    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state, state_next;
  logic ret_done, ret_done_next;
  logic pub;

  assign in_stall = (state != S_IDLE);
  assign pub = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next    = state;
    ret_done_next = ret_done;
    cmd.op        = OP_NONE;
    cmd.code      = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.size_zero) begin
          cmd.op = OP_STATUS;
          cmd.code = stat.act ? ST_OK : ST_NOFIT;
          state_next = S_DONE;
        end else begin
          state_next = stat.act ? S_SCAN_F : S_SCAN_A;
        end
      end
      S_SCAN_A: begin
        if (!stat.idx_lt) begin
          cmd.op = OP_STATUS;
          cmd.code = ST_NOFIT;
          state_next = S_DONE;
        end else if (stat.fit) begin
          cmd.op = OP_GRANT;
          ret_done_next = 1'b1;
          state_next = stat.exact ? S_REM : S_DONE;
        end else begin
          cmd.op = OP_STEP;
        end
      end
      S_SCAN_F: begin
        if (stat.idx_lt && !stat.above) begin
          cmd.op = OP_STEP;
        end else begin
          cmd.op = OP_SETPOS;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.pos_end && stat.beyond) begin
          cmd.op = OP_STATUS;
          cmd.code = ST_BEYOND;
          state_next = S_DONE;
        end else if (stat.full) begin
          cmd.op = OP_STATUS;
          cmd.code = ST_FULL;
          state_next = S_DONE;
        end else begin
          state_next = S_UP;
        end
      end
      S_UP: begin
        if (stat.idx_gt_pos) begin
          cmd.op = OP_UP;
        end else begin
          cmd.op = OP_INSERT;
          state_next = S_MERGEN;
        end
      end
      S_MERGEN: begin
        if (stat.next_ok) begin
          cmd.op = OP_MERGEN;
          ret_done_next = 1'b0;
          state_next = S_REM;
        end else begin
          state_next = S_MERGEP;
        end
      end
      S_MERGEP: begin
        if (stat.prev_ok) begin
          cmd.op = OP_MERGEP;
          ret_done_next = 1'b1;
          state_next = S_REM;
        end else begin
          state_next = S_DONE;
        end
      end
      S_REM: begin
        if (stat.rem_more) begin
          cmd.op = OP_DOWN;
        end else begin
          cmd.op = OP_DEC;
          state_next = ret_done ? S_DONE : S_MERGEP;
        end
      end
      S_DONE: begin
        if (pub) begin
          cmd.op = OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ret_done <= ret_done_next;
      if (pub) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pub_free: assert property (@(posedge clk) disable iff (rst)
    pub |-> (!out_valid || !out_stall)) else $error("result overwritten");
  a_pub_valid: assert property (@(posedge clk) disable iff (rst)
    pub |=> out_valid) else $error("result not presented");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD) |-> (state == S_IDLE && in_valid)) else $error("bad load");
`endif

endmodule

>>> rtl/core/first_fit_range_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator_core
// First-fit free-range allocator with coalescing over a configurable space.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid/in_stall    action, block_size, block_offset
//  out      output     out_valid/out_stall  status, granted_offset
//  cfg      APB        psel/penable/pready  space size at address 0
//
// The time one word takes is set by the one-entry-per-cycle table scan, the
// one-entry-per-cycle shift on insert and the shift for each removal after an
// exact fit or a merge. Reset, and every write of the space size, leave one
// range over the whole space, or no range if the size is zero. A stalled result
// waits in the output register while the next word is taken and worked on.
module first_fit_range_allocator_core #(
  parameter int MAX_RANGES  = ffra_pkg::DEF_MAX_RANGES,
  parameter int OFFSET_BITS = ffra_pkg::DEF_OFFSET_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] block_size,
  input  logic [31:0] block_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] granted_offset
);
  import ffra_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_wr;
  logic [31:0] space_limit;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == 2'd0);
  assign prdata = space_limit;

  ffra_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  ffra_datapath #(
    .MAX_RANGES(MAX_RANGES), .OFFSET_BITS(OFFSET_BITS)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_wr(cfg_wr), .cfg_data(pwdata), .space_limit(space_limit),
    .action(action), .block_size(block_size), .block_offset(block_offset),
    .cmd(cmd), .stat(stat),
    .status(status), .granted_offset(granted_offset)
  );

endmodule

>>> tb/ffra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_checker
// Watches the input, output and register channels of the range allocator,
// keeps its own copy of the free-range table, predicts the status and grant
// of every accepted word and compares them with the results in order.
// ----------------------------------------------------------------------------
module ffra_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action,
  input  logic [31:0] block_size,
  input  logic [31:0] block_offset,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [31:0] granted_offset,
  output int          pending,
  output int          errors
);
  import ffra_pkg::*;

  localparam int NR = DEF_MAX_RANGES;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] ofs;
  } grant_t;

  logic [31:0] space_size;
  logic [31:0] free_start [NR];
  logic [31:0] free_len [NR];
  int          free_count;
  grant_t      grant_q [$];

  task automatic init_free_table();
    for (int k = 0; k < NR; k++) begin
      free_start[k] = '0;
      free_len[k] = '0;
    end
    free_count = 0;
    if (space_size != 0) begin
      free_len[0] = space_size;
      free_count = 1;
    end
  endtask

  task automatic drop_range(int idx);
    for (int k = idx; k + 1 < free_count; k++) begin
      free_start[k] = free_start[k + 1];
      free_len[k] = free_len[k + 1];
    end
    free_count--;
    free_start[free_count] = '0;
    free_len[free_count] = '0;
  endtask

  task automatic predict_grant(logic act, logic [31:0] sz, logic [31:0] ofs,
                               output grant_t g);
    int pos;
    g.st = ST_OK;
    g.ofs = '0;
    if (!act) begin
      g.st = ST_NOFIT;
      if (sz != 0) begin
        for (int i = 0; i < free_count; i++) begin
          if (free_len[i] >= sz) begin
            g.ofs = free_start[i];
            free_start[i] = free_start[i] + sz;
            free_len[i] = free_len[i] - sz;
            if (free_len[i] == 0) drop_range(i);
            g.st = ST_OK;
            break;
          end
        end
      end
    end else if (sz != 0) begin
      pos = free_count;
      for (int i = 0; i < free_count; i++) begin
        if (free_start[i] > ofs) begin
          pos = i;
          break;
        end
      end
      if (pos == free_count && ({1'b0, ofs} + {1'b0, sz} > {1'b0, space_size})) begin
        g.st = ST_BEYOND;
      end else if (free_count >= NR) begin
        g.st = ST_FULL;
      end else begin
        for (int k = free_count; k > pos; k--) begin
          free_start[k] = free_start[k - 1];
          free_len[k] = free_len[k - 1];
        end
        free_start[pos] = ofs;
        free_len[pos] = sz;
        free_count++;
        if (pos + 1 < free_count &&
            {1'b0, free_start[pos]} + {1'b0, free_len[pos]} == {1'b0, free_start[pos + 1]}) begin
          free_len[pos] = free_len[pos] + free_len[pos + 1];
          drop_range(pos + 1);
        end
        if (pos > 0 &&
            {1'b0, free_start[pos - 1]} + {1'b0, free_len[pos - 1]} == {1'b0, free_start[pos]}) begin
          free_len[pos - 1] = free_len[pos - 1] + free_len[pos];
          drop_range(pos);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    grant_t g;
    grant_t w;
    if (rst) begin
      space_size = TOTAL_RESET;
      init_free_table();
      grant_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected word status=%0d granted_offset=%h",
                   $time, status, granted_offset);
          errors++;
        end else begin
          w = grant_q.pop_front();
          if (status !== w.st) begin
            $display("%0t: status expected %0d actual %0d", $time, w.st, status);
            errors++;
          end
          if (granted_offset !== w.ofs) begin
            $display("%0t: granted_offset expected %h actual %h",
                     $time, w.ofs, granted_offset);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_grant(action, block_size, block_offset, g);
        grant_q.push_back(g);
      end
      if (psel && penable && pwrite && pready && paddr == 2'd0) begin
        space_size = pwdata;
        init_free_table();
      end
    end
    pending = grant_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the range allocator with directed and random allocate and free
// words under several space sizes, with random gaps and output stalls, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import ffra_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [31:0] block_size = '0, block_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] granted_offset;
  int          pending, errors;
  int          cycles = 0;
  logic [31:0] cur_size;

  localparam int LIMIT = 1000000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  first_fit_range_allocator_core dut (.*);

  ffra_checker chk (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    int r;
    if (!rst) begin
      r = $urandom_range(0, 99);
      if (cycles % 2000 < 400) out_stall <= 1'b0;
      else if (r < 70) out_stall <= 1'b0;
      else if (r < 97) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(logic a, logic [31:0] sz, logic [31:0] ofs);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    action = a;
    block_size = sz;
    block_offset = ofs;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_space(logic [31:0] v);
    wait_drained();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 2'd0;
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    cur_size = v;
  endtask

  task automatic random_phase(int n);
    logic [31:0] lim, sz, ofs;
    int r;
    lim = cur_size >> 3;
    if (lim == 0) lim = 1;
    if (lim > 1024) lim = 1024;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        if ($urandom_range(0, 1) == 0) begin
          send_word(1'b0, 32'($urandom_range(1, lim)), $urandom);
        end else begin
          sz = $urandom_range(1, 16);
          ofs = (cur_size == 0) ? 32'($urandom_range(0, 8)) :
                32'($urandom_range(0, cur_size - 1));
          send_word(1'b1, sz, ofs);
        end
      end else if (r < 90) begin
        send_word(1'($urandom_range(0, 1)), $urandom, $urandom);
      end else begin
        send_word(1'($urandom_range(0, 1)), $urandom_range(0, 2), $urandom_range(0, 4));
      end
    end
  endtask

  initial begin
    cur_size = TOTAL_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_word(1'b0, 32'd0, 32'd0);
    send_word(1'b1, 32'd0, 32'd5);
    send_word(1'b0, 32'd65537, 32'hFFFFFFFF);
    send_word(1'b0, 32'd16, 32'd0);
    send_word(1'b0, 32'd16, 32'd0);
    send_word(1'b1, 32'd16, 32'd0);
    send_word(1'b1, 32'd16, 32'd16);
    send_word(1'b1, 32'd1, 32'd65536);
    send_word(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_word(1'b0, 32'd65536, 32'd0);
    send_word(1'b0, 32'd1, 32'd0);
    for (int k = 0; k < 17; k++) send_word(1'b1, 32'd1, 32'(2 * k));

    write_space(32'd0);
    send_word(1'b0, 32'd1, 32'd0);
    send_word(1'b1, 32'd5, 32'd0);
    random_phase(40);

    write_space(32'hFFFFFFFF);
    send_word(1'b0, 32'hFFFFFFFF, 32'd0);
    send_word(1'b1, 32'hFFFFFFFF, 32'd0);
    random_phase(200);

    write_space(32'd1);
    random_phase(100);
    write_space(32'd256);
    random_phase(250);
    write_space(32'd64);
    random_phase(200);
    write_space(32'd65536);
    random_phase(200);

    wait_drained();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
